@@ design/utf8_terminal_cell_mapper_defines.svh @@
// Assertion macros for the cell mapper.
`ifndef UTF8_TERMINAL_CELL_MAPPER_DEFINES_SVH
`define UTF8_TERMINAL_CELL_MAPPER_DEFINES_SVH
// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("assertion failed");
// Check that a condition always holds.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`endif

@@ design/u8tcm_pkg.sv @@
package u8tcm_pkg;
  localparam int TabWidth = 8;
  localparam int PhaseW = $clog2(TabWidth) > 0 ? $clog2(TabWidth) : 1;
  localparam logic [23:0] PosMax = 24'hFFFFFF;
  localparam int QDepth = 4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BADQ, ST_BADRAW, ST_GLYPH, ST_TAB
  } st_t;

  typedef enum logic [1:0] {
    GK_DROP, GK_TAB, GK_UNSAFE, GK_PLAIN
  } kind_t;

  // Work item passed from front to back: one byte plus context.
  typedef struct packed {
    logic [7:0] data;
    logic first;
    logic last;
    logic [15:0] scol;
    logic [23:0] spos;
  } item_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0] len;
    logic [23:0] s;
    logic [23:0] e;
    logic last;
  } cell_t;

  function automatic logic [23:0] sat_add(logic [23:0] p, logic [2:0] n);
    logic [24:0] r;
    r = {1'b0, p} + {22'd0, n};
    return r[24] ? PosMax : r[23:0];
  endfunction

  function automatic logic [2:0] seq_length(logic [7:0] b);
    if (!b[7]) return 3'd1;
    if (b[7:5] == 3'b110) return 3'd2;
    if (b[7:4] == 4'b1110) return 3'd3;
    if (b[7:3] == 5'b11110) return 3'd4;
    return 3'd1;
  endfunction

  function automatic logic is_cont(logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic in_rng(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
    return c >= lo && c <= hi;
  endfunction

  function automatic logic is_unsafe(logic [20:0] c);
    logic u;
    u = (c < 21'h20) || (c == 21'h7F);
    u |= in_rng(c, 21'h0300, 21'h036F) | in_rng(c, 21'h1AB0, 21'h1AFF);
    u |= in_rng(c, 21'h1DC0, 21'h1DFF) | in_rng(c, 21'h20D0, 21'h20FF);
    u |= in_rng(c, 21'hFE20, 21'hFE2F) | in_rng(c, 21'h200B, 21'h200F);
    u |= in_rng(c, 21'h202A, 21'h202E) | in_rng(c, 21'h2060, 21'h206F);
    u |= in_rng(c, 21'hFE00, 21'hFE0F) | in_rng(c, 21'hE0100, 21'hE01EF);
    u |= in_rng(c, 21'h1100, 21'h115F) | in_rng(c, 21'h2329, 21'h232A);
    u |= in_rng(c, 21'h2E80, 21'hA4CF) | in_rng(c, 21'hAC00, 21'hD7A3);
    u |= in_rng(c, 21'hF900, 21'hFAFF) | in_rng(c, 21'hFE10, 21'hFE19);
    u |= in_rng(c, 21'hFE30, 21'hFE6F) | in_rng(c, 21'hFF00, 21'hFF60);
    u |= in_rng(c, 21'hFFE0, 21'hFFE6) | in_rng(c, 21'h1F000, 21'h1FAFF);
    u |= in_rng(c, 21'h20000, 21'h3FFFD);
    return u;
  endfunction

  function automatic logic [20:0] decode_bits(logic [31:0] w, logic [2:0] n);
    case (n)
      3'd2: return {10'd0, w[4:0], w[13:8]};
      3'd3: return {5'd0, w[3:0], w[13:8], w[21:16]};
      3'd4: return {w[2:0], w[13:8], w[21:16], w[29:24]};
      default: return {13'd0, w[7:0]};
    endcase
  endfunction
endpackage

@@ design/u8tcm_if.sv @@
interface u8tcm_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic first_of_text;
  logic last_of_text;
  logic signed [15:0] start_column;
  logic [23:0] source_start;
  modport source(output valid, data_byte, first_of_text, last_of_text, start_column,
                 source_start, input ready);
  modport sink(input valid, data_byte, first_of_text, last_of_text, start_column,
               source_start, output ready);
endinterface

interface u8tcm_out_if;
  logic valid;
  logic ready;
  logic [31:0] cell_bytes;
  logic [2:0] cell_length;
  logic [23:0] cell_source_start;
  logic [23:0] cell_source_end;
  logic last_of_run;
  modport source(output valid, cell_bytes, cell_length, cell_source_start,
                 cell_source_end, last_of_run, input ready);
  modport sink(input valid, cell_bytes, cell_length, cell_source_start,
               cell_source_end, last_of_run, output ready);
endinterface

@@ design/u8tcm_front.sv @@
module u8tcm_front
  import u8tcm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  u8tcm_in_if.sink in_ch,
  output logic q_valid,
  input  logic q_ready,
  output item_t q_item
);
  localparam int QW = $clog2(QDepth);
  item_t mem [QDepth];
  logic [QW-1:0] wp, rp;
  logic [QW:0] cnt;
  logic push, pop;

  assign in_ch.ready = cnt != (QW+1)'(QDepth);
  assign push = in_ch.valid && in_ch.ready;
  assign pop = q_valid && q_ready;
  assign q_valid = cnt != '0;
  assign q_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QW+1)'(push) - (QW+1)'(pop);
    end
    if (push) begin
      mem[wp] <= '{in_ch.data_byte, in_ch.first_of_text, in_ch.last_of_text,
                   in_ch.start_column, in_ch.source_start};
    end
  end
endmodule

@@ design/u8tcm_back.sv @@
`include "utf8_terminal_cell_mapper_defines.svh"
module u8tcm_back
  import u8tcm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  item_t q_item,
  u8tcm_out_if.source out_ch
);
  st_t st, st_next, tail_st, tail_st_next;
  logic [31:0] pend, pend_next;
  logic [2:0] pcnt, pcnt_next;
  logic [PhaseW-1:0] phase, phase_first, ph_inc;
  logic [23:0] lpos, lpos_next;
  logic [2:0] j;
  logic [2:0] bad_c;
  logic [23:0] bad_lp;
  logic [31:0] bad_w;
  logic tail, tail_next;
  kind_t gk, gk_next;
  logic [31:0] gw, gw_next;
  logic [2:0] gn, gn_next;
  logic [23:0] gs, gs_next;
  logic ovalid;
  cell_t ocell, ecell;
  logic emit, accept, out_free;

  logic [7:0] b;
  logic [2:0] need;
  logic [23:0] lp0, fresh_pos;
  logic [2:0] pc0;
  logic [15:0] col;
  logic bad_next, do_fresh, gv;
  logic [7:0] raw_b;
  logic [23:0] raw_s;

  function automatic kind_t gkind(logic [31:0] w, logic [2:0] n);
    logic [20:0] cp;
    cp = decode_bits(w, n);
    if (cp == 21'h0D) return GK_DROP;
    if (cp == 21'h09) return GK_TAB;
    if (is_unsafe(cp)) return GK_UNSAFE;
    return GK_PLAIN;
  endfunction

  function automatic logic [31:0] mask_w(logic [31:0] w, logic [2:0] n);
    case (n)
      3'd1: return {24'd0, w[7:0]};
      3'd2: return {16'd0, w[15:0]};
      3'd3: return {8'd0, w[23:0]};
      default: return w;
    endcase
  endfunction

  assign out_free = !ovalid || out_ch.ready;
  assign accept = q_valid && q_ready;

  assign out_ch.valid = ovalid;
  assign out_ch.cell_bytes = ocell.bytes;
  assign out_ch.cell_length = ocell.len;
  assign out_ch.cell_source_start = ocell.s;
  assign out_ch.cell_source_end = ocell.e;
  assign out_ch.last_of_run = ocell.last;

  always_comb begin
    ph_inc = (phase == PhaseW'(TabWidth - 1)) ? '0 : phase + 1'b1;
  end

  always_comb begin
    case (j)
      3'd1: raw_b = bad_w[15:8];
      3'd2: raw_b = bad_w[23:16];
      default: raw_b = bad_w[31:24];
    endcase
    raw_s = sat_add(bad_lp, j);
  end

  // Work out everything one byte does when it is taken from the queue
  always_comb begin
    b = q_item.data;
    col = q_item.scol[15] ? 16'd0 : q_item.scol;
    phase_first = PhaseW'(col % TabWidth);
    pc0 = q_item.first ? 3'd0 : pcnt;
    lp0 = q_item.first ? q_item.spos : lpos;
    need = seq_length(pend[7:0]);
    pend_next = pend;
    pcnt_next = pc0;
    lpos_next = lp0;
    bad_next = 1'b0;
    fresh_pos = lp0;
    do_fresh = 1'b0;
    gv = 1'b0;
    gw_next = {24'd0, b};
    gn_next = 3'd1;
    gs_next = lp0;
    if (pc0 == 3'd0) begin
      do_fresh = 1'b1;
    end else if (is_cont(b)) begin
      case (pc0)
        3'd1: pend_next[15:8] = b;
        3'd2: pend_next[23:16] = b;
        default: pend_next[31:24] = b;
      endcase
      if (pc0 + 3'd1 >= need) begin
        gv = 1'b1;
        gw_next = pend_next;
        gn_next = need;
        gs_next = lp0;
        lpos_next = sat_add(lp0, need);
        pcnt_next = 3'd0;
      end else begin
        pcnt_next = pc0 + 3'd1;
      end
    end else begin
      bad_next = 1'b1;
      fresh_pos = sat_add(lp0, pc0);
      do_fresh = 1'b1;
    end
    if (do_fresh) begin
      if (seq_length(b) == 3'd1) begin
        gv = 1'b1;
        gw_next = {24'd0, b};
        gn_next = 3'd1;
        gs_next = fresh_pos;
        lpos_next = sat_add(fresh_pos, 3'd1);
        pcnt_next = 3'd0;
      end else begin
        pend_next = {24'd0, b};
        pcnt_next = 3'd1;
        lpos_next = fresh_pos;
      end
    end
    if (q_item.last && pcnt_next != 3'd0) begin
      gv = 1'b1;
      gw_next = pend_next;
      gn_next = pcnt_next;
      gs_next = lpos_next;
      lpos_next = sat_add(lpos_next, pcnt_next);
      pcnt_next = 3'd0;
    end
    gk_next = gkind(gw_next, gn_next);
    tail_next = gv && (gk_next != GK_DROP);
  end

  assign tail_st = !tail ? ST_IDLE : ((gk == GK_TAB) ? ST_TAB : ST_GLYPH);
  assign tail_st_next = !tail_next ? ST_IDLE : ((gk_next == GK_TAB) ? ST_TAB : ST_GLYPH);

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (q_valid) st_next = bad_next ? ST_BADQ : tail_st_next;
      ST_BADQ: if (out_free) st_next = (bad_c > 3'd1) ? ST_BADRAW : tail_st;
      ST_BADRAW: if (out_free && j == bad_c - 3'd1) st_next = tail_st;
      ST_GLYPH: if (out_free) st_next = ST_IDLE;
      ST_TAB: if (out_free && ph_inc == '0) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = 1'b0;
    emit = 1'b0;
    ecell = '0;
    unique case (st)
      ST_IDLE: q_ready = 1'b1;
      ST_BADQ: begin
        emit = out_free;
        ecell = '{32'h3F, 3'd1, bad_lp, sat_add(bad_lp, 3'd1), !tail && bad_c == 3'd1};
      end
      ST_BADRAW: begin
        emit = out_free;
        ecell = '{{24'd0, raw_b}, 3'd1, raw_s, sat_add(raw_s, 3'd1),
                  !tail && j == bad_c - 3'd1};
      end
      ST_GLYPH: begin
        emit = out_free;
        ecell = '{(gk == GK_UNSAFE) ? 32'h3F : mask_w(gw, gn),
                  (gk == GK_UNSAFE) ? 3'd1 : gn, gs, sat_add(gs, gn), 1'b1};
      end
      ST_TAB: begin
        emit = out_free;
        ecell = '{32'h20, 3'd1, gs, sat_add(gs, gn), ph_inc == '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      pend <= '0;
      pcnt <= '0;
      phase <= '0;
      lpos <= '0;
      ovalid <= 1'b0;
      ocell <= '0;
      j <= '0;
      bad_c <= '0;
      bad_lp <= '0;
      bad_w <= '0;
      tail <= 1'b0;
      gk <= GK_DROP;
      gw <= '0;
      gn <= '0;
      gs <= '0;
    end else begin
      st <= st_next;
      if (emit) begin
        ocell <= ecell;
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
      if (accept) begin
        pend <= pend_next;
        pcnt <= pcnt_next;
        lpos <= lpos_next;
        if (q_item.first) phase <= phase_first;
        bad_c <= pc0;
        bad_lp <= lp0;
        bad_w <= pend;
        tail <= tail_next;
        gk <= gk_next;
        gw <= gw_next;
        gn <= gn_next;
        gs <= gs_next;
        j <= 3'd1;
      end else if (emit) begin
        phase <= ph_inc;
        if (st == ST_BADRAW) j <= j + 3'd1;
      end
    end
  end

  `ASSERT_ALWAYS(a_pcnt_range, clk, rst, pcnt <= 3'd4)
  `ASSERT_NEXT(a_hold_out, clk, rst, ovalid && !out_ch.ready, ovalid)
  `ASSERT_NEXT(a_hold_cell, clk, rst, ovalid && !out_ch.ready, $stable(ocell))
  `ASSERT_ALWAYS(a_len_range, clk, rst, !ovalid || (ocell.len != 3'd0 && ocell.len <= 3'd4))
endmodule

@@ design/utf8_terminal_cell_mapper.sv @@
// UTF-8 terminal cell mapper.
// Channel in_ch carries text bytes with first/last markers; the column and
// source position are loaded on the first byte of a text.
// Channel out_ch carries terminal cells: bytes, length, source span, and a
// flag on the final cell produced by an input byte.
// A four-entry queue decouples byte intake from cell generation.
// The back end takes a queued byte only while idle, then emits its cells in
// turn: a plain byte one cell, a held lead or continuation byte or a carriage
// return none, a tab one space per column up to the next tab stop, a bad
// continuation a '?' and one raw cell per further held byte, then the new
// byte's cells. Each cell is presented from the registered output stage.
// The output register holds a cell while out_ch.ready is low and the back end
// stalls behind it; the queue keeps taking bytes until four are waiting.
// Reset empties the queue, drops any open sequence and clears the column
// phase and source position to zero.
// An input byte that yields no cell produces no output transaction.
module utf8_terminal_cell_mapper
  import u8tcm_pkg::*;
(
  input logic clk,
  input logic rst,
  u8tcm_in_if.sink in_ch,
  u8tcm_out_if.source out_ch
);
  logic q_valid, q_ready;
  item_t q_item;

  u8tcm_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  u8tcm_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item), .out_ch(out_ch)
  );
endmodule
